>>> rtl/ca3d_pkg.sv
// Shared types and constants for the 3D cellular automaton step block.
package ca3d_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register field widths
    localparam int RULE_W  = 5;
    localparam int DIM_W   = 7;
    localparam int DEPTH_W = 16;

    // Neighborhood layout: nine rows (3 in y by 3 in z) of three cells in x
    localparam int NUM_ROWS   = 9;
    localparam int ROW_TAPS   = 3;
    localparam int NUM_TAPS   = NUM_ROWS * ROW_TAPS;
    localparam int CENTER_TAP = NUM_TAPS / 2;
    localparam int COUNT_W    = 5;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BORN_MIN    = 3'd0,
        CFG_BORN_MAX    = 3'd1,
        CFG_DIE_MIN     = 3'd2,
        CFG_DIE_MAX     = 3'd3,
        CFG_GRID_WIDTH  = 3'd4,
        CFG_GRID_HEIGHT = 3'd5,
        CFG_GRID_DEPTH  = 3'd6
    } cfg_reg_t;

    // Birth and death thresholds handed to the rule stage
    typedef struct packed {
        logic [RULE_W-1:0] born_min;
        logic [RULE_W-1:0] born_max;
        logic [RULE_W-1:0] die_min;
        logic [RULE_W-1:0] die_max;
    } rule_cfg_t;

endpackage

>>> rtl/ca3d_line_ram.sv
// Simple dual-port RAM holding one slice of the window delay line.
module ca3d_line_ram #(
    parameter int DEPTH = 8327,
    parameter int DW = 3,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/ca3d_rule.sv
// Neighbor count and birth/death rule for one cell.
module ca3d_rule
    import ca3d_pkg::*;
(
    input  rule_cfg_t             cfg,
    input  logic [NUM_TAPS-1:0]   taps,
    input  logic                  interior,
    output logic                  next_cell
);

    logic [1:0]          row_cnt [NUM_ROWS];
    logic [3:0]          plane_cnt [ROW_TAPS];
    logic [COUNT_W-1:0]  count;
    logic                center;

    assign center = taps[CENTER_TAP];

    // Per-row counts, the center cell left out of its row
    always_comb
    begin
        for (int j = 0; j < NUM_ROWS; j++)
        begin
            row_cnt[j] = 2'(taps[j*ROW_TAPS]) + 2'(taps[j*ROW_TAPS+2]);
            if ((j*ROW_TAPS + 1) != CENTER_TAP)
            begin
                row_cnt[j] = row_cnt[j] + 2'(taps[j*ROW_TAPS+1]);
            end
        end
    end

    // Per-plane counts, then the full neighbor count
    always_comb
    begin
        for (int c = 0; c < ROW_TAPS; c++)
        begin
            plane_cnt[c] = 4'(row_cnt[c*ROW_TAPS]) + 4'(row_cnt[c*ROW_TAPS+1])
                         + 4'(row_cnt[c*ROW_TAPS+2]);
        end
        count = COUNT_W'(plane_cnt[0]) + COUNT_W'(plane_cnt[1]) + COUNT_W'(plane_cnt[2]);
    end

    // Shell cells keep their value; interior cells follow the rule
    always_comb
    begin
        next_cell = center;
        if (interior)
        begin
            if (center && (count <= cfg.die_max || count >= cfg.die_min))
            begin
                next_cell = 1'b0;
            end
            else if (!center && count >= cfg.born_min && count <= cfg.born_max)
            begin
                next_cell = 1'b1;
            end
        end
    end

endmodule

>>> rtl/cellular_automaton_3d_step_top.sv
// Top level of the 3D cellular automaton step block.
//
// Takes one cell (or one flush) per cycle while cell_stall is low and gives at most one
// result per item; an accepted item passes stage A and stage B before its result reaches the output register. A
// result belongs to the cell W*H + W + 1 positions back in the stream; flush items move
// the window on once the whole grid is in, to drain those last results. The window lives
// in nine RAM slices of 2*MAX_WIDTH*MAX_HEIGHT + 2*MAX_WIDTH + 7 words of three cells,
// one slice for each row of the 3x3x3 neighborhood, each read once per cycle unless the
// output is held; a fill count stands in for the all-dead state after reset, so there
// is no clearing pass. After reset and after every configuration write the input
// stalls while the grid products (W*H, cell total, tap offsets) are recomputed.
module cellular_automaton_3d_step_top
    import ca3d_pkg::*;
#(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   cell_valid,
    output logic                   cell_stall,
    input  logic                   cell_in,
    input  logic                   flush,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic                   cell_out,
    output logic                   last_cell
);

    localparam int XW  = $clog2(MAX_WIDTH + 1);
    localparam int YW  = $clog2(MAX_HEIGHT + 1);
    localparam int OXW = $clog2(MAX_WIDTH);
    localparam int OYW = $clog2(MAX_HEIGHT);
    localparam int WHW = XW + YW;
    localparam int PW  = WHW + DEPTH_W;
    localparam int LINE_DEPTH = 2 * MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3;
    localparam int LW  = $clog2(LINE_DEPTH);
    localparam int FW  = $clog2(LINE_DEPTH + 1);
    localparam int MEM_DEPTH = LINE_DEPTH + 4;
    localparam int AW  = $clog2(MEM_DEPTH);
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    // Configuration registers
    logic [RULE_W-1:0]  born_min_reg, born_max_reg, die_min_reg, die_max_reg;
    logic [DIM_W-1:0]   grid_width_reg, grid_height_reg;
    logic [DEPTH_W-1:0] grid_depth_reg;
    logic [1:0]         settle_cnt_reg;
    rule_cfg_t          rule_cfg;

    // Grid geometry
    logic [XW-1:0]      w_clamp;
    logic [YW-1:0]      h_clamp;
    logic [DEPTH_W-1:0] d_clamp;
    logic [WHW-1:0]     wh_reg;
    logic [PW-1:0]      total_prod;
    logic [31:0]        total_reg;
    logic [LW-1:0]      lag_reg;
    logic [LW-1:0]      base_reg [NUM_ROWS];

    // Stream state
    logic [31:0]        received_count_reg;
    logic [OXW-1:0]     out_x_reg;
    logic [OYW-1:0]     out_y_reg;
    logic [DEPTH_W-1:0] out_z_reg;
    logic [AW-1:0]      wp_reg;
    logic [FW-1:0]      fill_reg;
    logic               pos0_reg, pos1_reg;

    // Input decode
    logic               pipe_en, accept, grid_full, shift, shift_val, produce;
    logic               last_hit, interior;
    logic               x_wrap, y_wrap, z_wrap;
    logic [31:0]        rc_inc;
    logic [AW-1:0]      wp_next;
    logic [FW-1:0]      fill_next;
    logic [ROW_TAPS-1:0] wdata;

    // Pipeline stages
    logic               a_v_reg, b_v_reg, result_valid_reg;
    logic [AW-1:0]      a_ptr_reg;
    logic [FW-1:0]      a_fill_reg;
    logic               a_interior_reg, a_last_reg;
    logic [NUM_TAPS-1:0] a_mask, b_mask_reg;
    logic               b_interior_reg, b_last_reg;
    logic [AW-1:0]      raddr [NUM_ROWS];
    logic [ROW_TAPS-1:0] rdata [NUM_ROWS];
    logic [NUM_TAPS-1:0] taps;
    logic               next_cell;
    logic               cell_out_reg, last_cell_reg;

    // Dimension saturation
    always_comb
    begin
        if (int'(grid_width_reg) < 3)
            w_clamp = XW'(3);
        else if (int'(grid_width_reg) > MAX_WIDTH)
            w_clamp = XW'(MAX_WIDTH);
        else
            w_clamp = XW'(grid_width_reg);

        if (int'(grid_height_reg) < 3)
            h_clamp = YW'(3);
        else if (int'(grid_height_reg) > MAX_HEIGHT)
            h_clamp = YW'(MAX_HEIGHT);
        else
            h_clamp = YW'(grid_height_reg);

        d_clamp = (grid_depth_reg < DEPTH_W'(3)) ? DEPTH_W'(3) : grid_depth_reg;
    end

    assign total_prod = PW'(wh_reg) * PW'(d_clamp);

    // Geometry products, registered from the clamped dimensions and from W*H
    always_ff @(posedge clk)
    begin
        wh_reg    <= WHW'(w_clamp) * WHW'(h_clamp);
        total_reg <= 32'(total_prod);
        lag_reg   <= LW'(int'(wh_reg) + int'(w_clamp) + 1);
        for (int j = 0; j < NUM_ROWS; j++)
        begin
            base_reg[j] <= LW'((j / ROW_TAPS) * int'(wh_reg) + (j % ROW_TAPS) * int'(w_clamp));
        end
    end

    assign rule_cfg.born_min = born_min_reg;
    assign rule_cfg.born_max = born_max_reg;
    assign rule_cfg.die_min  = die_min_reg;
    assign rule_cfg.die_max  = die_max_reg;

    // Handshake
    assign pipe_en    = !(result_valid_reg && result_stall);
    assign cell_stall = !pipe_en || (settle_cnt_reg != 2'd0);
    assign accept     = cell_valid && !cell_stall;

    // Decode of one input item against the stream position
    always_comb
    begin
        grid_full = received_count_reg >= total_reg;
        shift     = accept && !(flush && !grid_full);
        shift_val = !flush && !grid_full && cell_in;
        rc_inc    = (received_count_reg == 32'hFFFF_FFFF) ? received_count_reg
                                                          : received_count_reg + 32'd1;
        produce   = rc_inc > 32'(lag_reg);

        x_wrap   = XW'(out_x_reg) >= (w_clamp - XW'(1));
        y_wrap   = YW'(out_y_reg) >= (h_clamp - YW'(1));
        z_wrap   = out_z_reg >= (d_clamp - DEPTH_W'(1));
        last_hit = x_wrap && y_wrap && z_wrap;
        interior = (out_x_reg != '0) && !x_wrap && (out_y_reg != '0) && !y_wrap
                && (out_z_reg != '0) && !z_wrap;

        wp_next   = (wp_reg == AW'(MEM_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        fill_next = (fill_reg == FW'(LINE_DEPTH)) ? fill_reg : fill_reg + FW'(1);
        wdata     = {pos1_reg, pos0_reg, shift_val};
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            born_min_reg       <= RULE_W'(5);
            born_max_reg       <= RULE_W'(7);
            die_min_reg        <= RULE_W'(8);
            die_max_reg        <= RULE_W'(3);
            grid_width_reg     <= DIM_W'(64);
            grid_height_reg    <= DIM_W'(64);
            grid_depth_reg     <= DEPTH_W'(64);
            settle_cnt_reg     <= SETTLE_CYCLES;
            received_count_reg <= '0;
            out_x_reg          <= '0;
            out_y_reg          <= '0;
            out_z_reg          <= '0;
            wp_reg             <= '0;
            fill_reg           <= '0;
            pos0_reg           <= 1'b0;
            pos1_reg           <= 1'b0;
            a_v_reg            <= 1'b0;
            b_v_reg            <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            // Register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BORN_MIN:    born_min_reg    <= cfg_data[RULE_W-1:0];
                    CFG_BORN_MAX:    born_max_reg    <= cfg_data[RULE_W-1:0];
                    CFG_DIE_MIN:     die_min_reg     <= cfg_data[RULE_W-1:0];
                    CFG_DIE_MAX:     die_max_reg     <= cfg_data[RULE_W-1:0];
                    CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[DIM_W-1:0];
                    CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[DIM_W-1:0];
                    CFG_GRID_DEPTH:  grid_depth_reg  <= cfg_data[DEPTH_W-1:0];
                    default:         ;
                endcase
            end

            // Hold the input off while the geometry products settle
            if (cfg_we)
                settle_cnt_reg <= SETTLE_CYCLES;
            else if (settle_cnt_reg != 2'd0)
                settle_cnt_reg <= settle_cnt_reg - 2'd1;

            // Window shift and output coordinates
            if (shift)
            begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
                pos0_reg <= shift_val;
                pos1_reg <= pos0_reg;
                received_count_reg <= (produce && last_hit) ? '0 : rc_inc;
                if (produce)
                begin
                    if (x_wrap)
                    begin
                        out_x_reg <= '0;
                        if (y_wrap)
                        begin
                            out_y_reg <= '0;
                            out_z_reg <= z_wrap ? '0 : out_z_reg + DEPTH_W'(1);
                        end
                        else
                        begin
                            out_y_reg <= out_y_reg + OYW'(1);
                        end
                    end
                    else
                    begin
                        out_x_reg <= out_x_reg + OXW'(1);
                    end
                end
            end

            // Stage valids
            if (pipe_en)
            begin
                a_v_reg          <= shift && produce;
                b_v_reg          <= a_v_reg;
                result_valid_reg <= b_v_reg;
            end
        end
    end

    // Read addresses and fill masks for the item in stage A
    always_comb
    begin
        for (int j = 0; j < NUM_ROWS; j++)
        begin
            logic [AW:0] diff;
            diff = (AW+1)'(a_ptr_reg) - (AW+1)'(base_reg[j]);
            raddr[j] = diff[AW] ? AW'(diff + (AW+1)'(MEM_DEPTH)) : diff[AW-1:0];
            for (int k = 0; k < ROW_TAPS; k++)
            begin
                a_mask[j*ROW_TAPS+k] = (FW'(base_reg[j]) + FW'(k)) < a_fill_reg;
            end
        end
    end

    // Window RAM slices, one per neighborhood row
    for (genvar j = 0; j < NUM_ROWS; j++)
    begin : g_row
        ca3d_line_ram #(
            .DEPTH (MEM_DEPTH),
            .DW    (ROW_TAPS)
        ) u_ram (
            .clk   (clk),
            .we    (shift),
            .waddr (wp_next),
            .wdata (wdata),
            .re    (pipe_en),
            .raddr (raddr[j]),
            .rdata (rdata[j])
        );
        for (genvar k = 0; k < ROW_TAPS; k++)
        begin : g_tap
            assign taps[j*ROW_TAPS+k] = rdata[j][k] & b_mask_reg[j*ROW_TAPS+k];
        end
    end

    ca3d_rule u_rule (
        .cfg       (rule_cfg),
        .taps      (taps),
        .interior  (b_interior_reg),
        .next_cell (next_cell)
    );

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_ptr_reg      <= wp_next;
            a_fill_reg     <= fill_next;
            a_interior_reg <= interior;
            a_last_reg     <= last_hit;
            b_mask_reg     <= a_mask;
            b_interior_reg <= a_interior_reg;
            b_last_reg     <= a_last_reg;
            cell_out_reg   <= next_cell;
            last_cell_reg  <= b_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign cell_out     = cell_out_reg;
    assign last_cell    = last_cell_reg;

`ifndef SYNTHESIS
    // No item enters while the geometry products are settling
    a_settle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (settle_cnt_reg != 2'd0) |-> cell_stall)
        else $error("item accepted while geometry settles");

    // The final cell of a grid restarts the stream position
    a_grid_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (shift && produce && last_hit) |=> (received_count_reg == '0 && out_x_reg == '0
                                            && out_y_reg == '0 && out_z_reg == '0))
        else $error("stream position not cleared after last cell");

    // A held pipeline keeps the item in stage B
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (b_v_reg && !pipe_en) |=> (b_v_reg && $stable(b_mask_reg) && $stable(b_last_reg)))
        else $error("stage B changed while held");
`endif

endmodule
